// ===== src/odo_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table of the odometry unit.
// No dependencies; imported by odo_div, odo_cordic and the top level.
package odo_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 24;

  // fixed-point constants
  localparam logic signed [28:0] PI_Q24      = 29'sd52707179;
  localparam logic signed [28:0] HALF_PI_Q24 = 29'sd26353589;
  localparam logic signed [28:0] PERIOD_Q24  = 29'sd105414358;
  localparam logic [31:0]        PERIOD_U32  = 32'd105414358;
  localparam logic [28:0]        PERIOD_U29  = 29'd105414358;
  localparam logic [31:0]        PI_Q29      = 32'd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;

  // reciprocal constants
  localparam logic [31:0] PERIOD_RECIP = 32'd683565269;  // floor(2^56 / period)
  localparam logic [31:0] GYRO_INT     = 32'd16777;      // 2^24 div 1000
  localparam logic [24:0] GYRO_FRAC    = 25'd216;        // 2^24 mod 1000
  localparam logic [24:0] GYRO_HALF    = 25'd500;
  localparam logic [31:0] GYRO_RECIP   = 32'd274877907;  // ceil(2^38 / 1000)

  // divider word sizes
  localparam int unsigned DVD_W = 64;
  localparam int unsigned DVS_W = 32;
  localparam int unsigned CNT_W = 7;

  // configuration register indexes
  localparam logic [2:0] REG_LEFT_DIA  = 3'd0;
  localparam logic [2:0] REG_RIGHT_DIA = 3'd1;
  localparam logic [2:0] REG_TRACK     = 3'd2;
  localparam logic [2:0] REG_LEFT_CPR  = 3'd3;
  localparam logic [2:0] REG_RIGHT_CPR = 3'd4;
  localparam logic [2:0] REG_GEAR      = 3'd5;
  localparam logic [2:0] REG_USE_GYRO  = 3'd6;
  localparam logic [2:0] REG_GYRO_BIAS = 3'd7;

  typedef struct packed {
    logic               start;
    logic [DVD_W-1:0]   dividend;
    logic [DVS_W-1:0]   divisor;
    logic [CNT_W-1:0]   nbits;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DVD_W-1:0]   quot;
    logic [DVS_W-1:0]   rem;
  } div_rsp_t;

  // atan(2^-i) in Q24 radians
  function automatic logic [23:0] atan_q24(input logic [4:0] i);
    logic [23:0] r;
    case (i)
      5'd0:  r = 24'd13176795;
      5'd1:  r = 24'd7778716;
      5'd2:  r = 24'd4110060;
      5'd3:  r = 24'd2086331;
      5'd4:  r = 24'd1047214;
      5'd5:  r = 24'd524117;
      5'd6:  r = 24'd262123;
      5'd7:  r = 24'd131069;
      5'd8:  r = 24'd65536;
      5'd9:  r = 24'd32768;
      5'd10: r = 24'd16384;
      5'd11: r = 24'd8192;
      5'd12: r = 24'd4096;
      5'd13: r = 24'd2048;
      5'd14: r = 24'd1024;
      5'd15: r = 24'd512;
      5'd16: r = 24'd256;
      5'd17: r = 24'd128;
      5'd18: r = 24'd64;
      5'd19: r = 24'd32;
      5'd20: r = 24'd16;
      5'd21: r = 24'd8;
      5'd22: r = 24'd4;
      5'd23: r = 24'd2;
      5'd24: r = 24'd1;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/odo_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the odometry unit: encoder counts and gyro sample.
// No dependencies.
interface odo_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_count;
  logic signed [15:0] right_count;
  logic signed [15:0] gyro_z;

  modport source(output valid, left_count, right_count, gyro_z, input ready);
  modport sink(input valid, left_count, right_count, gyro_z, output ready);
endinterface

// ===== src/odo_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the odometry unit: the updated pose.
// No dependencies.
interface odo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [26:0] heading;

  modport source(output valid, pos_x, pos_y, heading, input ready);
  modport sink(input valid, pos_x, pos_y, heading, output ready);
endinterface

// ===== src/odo_mul.sv =====
`timescale 1ns / 1ps
// Shared 32x32 unsigned multiplier with registered product.
// Depends on nothing but its ports.
module odo_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== src/odo_div.sv =====
`timescale 1ns / 1ps
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on odo_pkg.
module odo_div
  import odo_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DVD_W-1:0] dvd_q, quot_q;
  logic [DVS_W-1:0] dvs_q, rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [DVS_W:0]   rem_sh, rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= req_i.nbits;
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      // align the top dividend bit to the msb
      dvd_q  <= req_i.dividend << (CNT_W'(DVD_W) - req_i.nbits);
      dvs_q  <= req_i.divisor;
      quot_q <= '0;
      rem_q  <= '0;
    end else if (cnt_q != '0) begin
      dvd_q  <= {dvd_q[DVD_W-2:0], 1'b0};
      quot_q <= {quot_q[DVD_W-2:0], ge};
      rem_q  <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== src/odo_cordic.sv =====
`timescale 1ns / 1ps
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on odo_pkg.
module odo_cordic
  import odo_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [26:0] angle_i,
  output logic               done_o,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);

  localparam int unsigned SW = $clog2(CORDIC_STEPS + 1);

  logic signed [33:0] x_q, y_q, xs, ys;
  logic signed [27:0] z_q, at;
  logic signed [28:0] ang;
  logic [SW-1:0]      i_q;
  logic               busy_q, done_q, flip_q;
  logic [4:0]         idx;

  assign ang = 29'(angle_i);
  assign idx = 5'(i_q);
  assign xs  = x_q >>> idx;
  assign ys  = y_q >>> idx;
  assign at  = 28'({4'b0, atan_q24(idx)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 1'b1;
        if (i_q == SW'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= CORDIC_GAIN;
      y_q <= '0;
      // fold into [-pi/2, pi/2], negate the result afterwards
      if (ang > HALF_PI_Q24) begin
        z_q    <= 28'(ang - PI_Q24);
        flip_q <= 1'b1;
      end else if (ang < -HALF_PI_Q24) begin
        z_q    <= 28'(ang + PI_Q24);
        flip_q <= 1'b1;
      end else begin
        z_q    <= 28'(ang);
        flip_q <= 1'b0;
      end
    end else if (busy_q) begin
      if (!z_q[27]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;

endmodule

// ===== src/differential_drive_odometry_unit.sv =====
`timescale 1ns / 1ps
// Differential-drive wheel odometry top level: sequencer, pose state, config.
// Depends on odo_pkg, odo_in_if, odo_out_if, odo_mul, odo_div, odo_cordic.
//
// Each input item (absolute left/right encoder counts, raw gyro z) yields one
// result item with the updated pose: x, y in 1/256 mm (saturating) and heading
// in Q24 rad wrapped to [-pi, pi). The unit takes one item at a time and drops
// ready while it works. A single radix-2 divider runs for the left travel, the
// right travel and, in encoder mode, the heading change; the CORDIC iterations
// follow. The gyro scaling and the modulo 2*pi reduction use reciprocal
// multiplies on the shared multiplier. A finished pose waits in an output
// register, so the next item is accepted while the previous result is still
// pending. Config writes must only happen while the unit is idle.
module differential_drive_odometry_unit
  import odo_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  odo_in_if.sink      in_i,
  odo_out_if.source   out_o
);

  typedef enum logic [20:0] {
    ST_IDLE  = 21'h000001,
    ST_CG    = 21'h000002,  // counts_per_rev * gear
    ST_DM    = 21'h000004,  // diameter * |delta|
    ST_PM    = 21'h000008,  // * pi
    ST_DIVW  = 21'h000010,
    ST_WAITW = 21'h000020,
    ST_HDIV  = 21'h000040,
    ST_WAITH = 21'h000080,
    ST_GI    = 21'h000100,  // gyro: integer part of 2^24/1000
    ST_GF    = 21'h000200,  // gyro: fractional part
    ST_MOD   = 21'h000400,  // quotient estimate by 2*pi
    ST_MQ    = 21'h000800,
    ST_MR    = 21'h001000,
    ST_MC    = 21'h002000,  // final remainder correction
    ST_HUP   = 21'h004000,
    ST_CORD  = 21'h008000,
    ST_WAITC = 21'h010000,
    ST_MX    = 21'h020000,
    ST_MY    = 21'h040000,
    ST_PY    = 21'h080000,
    ST_DONE  = 21'h100000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [15:0]        ldia_q, rdia_q, track_q;
  logic [11:0]        lcpr_q, rcpr_q;
  logic [9:0]         gear_q;
  logic               gyro_q;
  logic signed [15:0] bias_q;

  // item and pose state
  logic signed [15:0] lc_q, rc_q, gz_q;
  logic [15:0]        last_l_q, last_r_q;
  logic signed [31:0] x_q, y_q;
  logic signed [26:0] hd_q;
  logic               wsel_q;
  logic [21:0]        cg_q;
  logic signed [31:0] tl_q, tr_q;
  logic [63:0]        dmag_q;
  logic               dneg_q;
  logic [28:0]        mrem_q;
  logic signed [33:0] cos_q, sin_q;

  // output register
  logic               ov_q;
  logic signed [31:0] ox_q, oy_q;
  logic signed [26:0] oh_q;

  // shared units
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  div_req_t           dreq;
  div_rsp_t           drsp;
  logic               cstart, cdone;
  logic signed [33:0] ccos, csin;

  odo_mul u_mul (.clk_i, .a_i(mul_a), .b_i(mul_b), .p_o(mul_p));
  odo_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));
  odo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .start_i(cstart), .angle_i(hd_q),
    .done_o(cdone), .cos_o(ccos), .sin_o(csin)
  );

  // per-wheel operands; zero divisors count as one
  logic signed [15:0] delta;
  logic [15:0]        dmag, dia;
  logic [11:0]        cpr;
  logic [9:0]         gear;
  logic [15:0]        track;

  assign delta = wsel_q ? (rc_q - $signed(last_r_q)) : (lc_q - $signed(last_l_q));
  assign dmag  = delta[15] ? 16'(-delta) : 16'(delta);
  assign dia   = wsel_q ? rdia_q : ldia_q;
  assign cpr   = (wsel_q ? rcpr_q : lcpr_q) == '0 ? 12'd1 : (wsel_q ? rcpr_q : lcpr_q);
  assign gear  = (gear_q == '0) ? 10'd1 : gear_q;
  assign track = (track_q == '0) ? 16'd1 : track_q;

  // heading-change numerators
  logic signed [32:0] tdiff, psum;
  logic [32:0]        tdmag, smag;
  logic signed [16:0] gdiff;
  logic [16:0]        gmag;
  logic [24:0]        gfrac;

  assign tdiff = 33'(tr_q) - 33'(tl_q);
  assign tdmag = tdiff[32] ? 33'(-tdiff) : 33'(tdiff);
  assign gdiff = 17'(gz_q) - 17'(bias_q);
  assign gmag  = gdiff[16] ? 17'(-gdiff) : 17'(gdiff);
  assign psum  = 33'(tl_q) + 33'(tr_q);
  assign smag  = psum[32] ? 33'(-psum) : 33'(psum);
  // gmag*2^24 + 500 = gmag*16777*1000 + (gmag*216 + 500)
  assign gfrac = 25'(gmag) * GYRO_FRAC + GYRO_HALF;

  // trig magnitudes
  logic [31:0] cmag, snmag;
  logic [33:0] cabs, sabs;
  assign cabs  = cos_q[33] ? 34'(-cos_q) : 34'(cos_q);
  assign sabs  = sin_q[33] ? 34'(-sin_q) : 34'(sin_q);
  assign cmag  = cabs[31:0];
  assign snmag = sabs[31:0];

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_CG: begin
        mul_a = 32'(cpr);
        mul_b = 32'(gear);
      end
      ST_DM: begin
        mul_a = 32'(dia);
        mul_b = 32'(dmag);
      end
      ST_PM: begin
        mul_a = mul_p[31:0];
        mul_b = PI_Q29;
      end
      ST_HDIV: begin
        mul_a = 32'(gmag);
        mul_b = GYRO_INT;
      end
      ST_GI: begin
        mul_a = 32'(gfrac);
        mul_b = GYRO_RECIP;
      end
      ST_MOD: begin
        mul_a = dmag_q[55:24];
        mul_b = PERIOD_RECIP;
      end
      ST_MQ: begin
        mul_a = mul_p[63:32];
        mul_b = PERIOD_U32;
      end
      ST_MX: begin
        mul_a = smag[31:0];
        mul_b = cmag;
      end
      ST_MY: begin
        mul_a = smag[31:0];
        mul_b = snmag;
      end
      default: ;
    endcase
  end

  // divider requests; each rounds half away from zero via the +d/2 term
  logic [63:0] wnum;
  assign wnum = (mul_p + {14'b0, cg_q, 28'b0}) >> 29;

  always_comb begin
    dreq = '0;
    case (state_q)
      ST_DIVW: begin
        dreq.start    = 1'b1;
        dreq.dividend = wnum;
        dreq.divisor  = 32'(cg_q);
        dreq.nbits    = CNT_W'(35);
      end
      ST_HDIV: begin
        if (!gyro_q) begin
          dreq.start    = 1'b1;
          dreq.dividend = {7'b0, tdmag, 24'b0} + 64'(track[15:1]);
          dreq.divisor  = 32'(track);
          dreq.nbits    = CNT_W'(58);
        end
      end
      default: ;
    endcase
  end

  assign cstart = (state_q == ST_CORD);

  // wheel travel with sign and saturation
  logic signed [31:0] travel;
  always_comb begin
    if (!delta[15]) begin
      travel = (drsp.quot[63:31] != '0) ? 32'sh7fffffff : $signed(drsp.quot[31:0]);
    end else if (drsp.quot > 64'h8000_0000) begin
      travel = 32'sh80000000;
    end else begin
      travel = 32'(-$signed({1'b0, drsp.quot[31:0]}));
    end
  end

  // remainder estimate is at most two periods high
  logic [28:0] mr1, mr2;
  assign mr1 = (mrem_q >= PERIOD_U29) ? mrem_q - PERIOD_U29 : mrem_q;
  assign mr2 = (mr1 >= PERIOD_U29) ? mr1 - PERIOD_U29 : mr1;

  // new heading: add signed remainder, wrap once
  logic signed [28:0] rsig, hsum, hwrap;
  assign rsig = dneg_q ? -$signed({1'b0, mrem_q[27:0]}) : $signed({1'b0, mrem_q[27:0]});
  assign hsum = 29'(hd_q) + rsig;
  always_comb begin
    if (hsum >= PI_Q24) begin
      hwrap = hsum - PERIOD_Q24;
    end else if (hsum < -PI_Q24) begin
      hwrap = hsum + PERIOD_Q24;
    end else begin
      hwrap = hsum;
    end
  end

  // position update: acc + round(sum * trig / 2^31), saturated
  logic [65:0]        full;
  logic [34:0]        qmag;
  logic               pneg;
  logic signed [36:0] pnew;
  logic signed [31:0] pacc, psat;
  logic [31:0]        tmag;

  assign tmag = (state_q == ST_MY) ? cmag : snmag;
  assign pneg = psum[32] ^ ((state_q == ST_MY) ? cos_q[33] : sin_q[33]);
  assign pacc = (state_q == ST_MY) ? x_q : y_q;
  assign full = 66'(mul_p) + (smag[32] ? {2'b0, tmag, 32'b0} : 66'd0);
  assign qmag = 35'((full + 66'd1073741824) >> 31);
  assign pnew = 37'(pacc) + (pneg ? -$signed({2'b0, qmag}) : $signed({2'b0, qmag}));
  always_comb begin
    if (pnew > 37'sh7fffffff) begin
      psat = 32'sh7fffffff;
    end else if (pnew < -37'sh80000000) begin
      psat = 32'sh80000000;
    end else begin
      psat = 32'(pnew);
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_i.valid) state_d = ST_CG;
      ST_CG:    state_d = ST_DM;
      ST_DM:    state_d = ST_PM;
      ST_PM:    state_d = ST_DIVW;
      ST_DIVW:  state_d = ST_WAITW;
      ST_WAITW: if (drsp.done) state_d = wsel_q ? ST_HDIV : ST_CG;
      ST_HDIV:  state_d = gyro_q ? ST_GI : ST_WAITH;
      ST_WAITH: if (drsp.done) state_d = ST_MOD;
      ST_GI:    state_d = ST_GF;
      ST_GF:    state_d = ST_MOD;
      ST_MOD:   state_d = ST_MQ;
      ST_MQ:    state_d = ST_MR;
      ST_MR:    state_d = ST_MC;
      ST_MC:    state_d = ST_HUP;
      ST_HUP:   state_d = ST_CORD;
      ST_CORD:  state_d = ST_WAITC;
      ST_WAITC: if (cdone) state_d = ST_MX;
      ST_MX:    state_d = ST_MY;
      ST_MY:    state_d = ST_PY;
      ST_PY:    state_d = ST_DONE;
      ST_DONE:  if (!ov_q || out_o.ready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign in_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ldia_q   <= 16'd8192;
      rdia_q   <= 16'd8192;
      track_q  <= 16'd24576;
      lcpr_q   <= 12'd12;
      rcpr_q   <= 12'd12;
      gear_q   <= 10'd75;
      gyro_q   <= 1'b0;
      bias_q   <= '0;
      last_l_q <= '0;
      last_r_q <= '0;
      x_q      <= '0;
      y_q      <= '0;
      hd_q     <= '0;
      wsel_q   <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LEFT_DIA:  ldia_q  <= cfg_data_i;
          REG_RIGHT_DIA: rdia_q  <= cfg_data_i;
          REG_TRACK:     track_q <= cfg_data_i;
          REG_LEFT_CPR:  lcpr_q  <= cfg_data_i[11:0];
          REG_RIGHT_CPR: rcpr_q  <= cfg_data_i[11:0];
          REG_GEAR:      gear_q  <= cfg_data_i[9:0];
          REG_USE_GYRO:  gyro_q  <= cfg_data_i[0];
          REG_GYRO_BIAS: bias_q  <= cfg_data_i;
          default: ;
        endcase
      end
      // a new pose enters as the old one leaves
      if ((state_q == ST_DONE) && (!ov_q || out_o.ready)) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE:  wsel_q <= 1'b0;
        ST_WAITW: if (drsp.done) wsel_q <= 1'b1;
        ST_HUP:   hd_q <= 27'(hwrap);
        ST_MY:    x_q <= psat;
        ST_PY:    y_q <= psat;
        ST_DONE: begin
          if (!ov_q || out_o.ready) begin
            last_l_q <= lc_q;
            last_r_q <= rc_q;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          lc_q <= in_i.left_count;
          rc_q <= in_i.right_count;
          gz_q <= in_i.gyro_z;
        end
      end
      ST_DM: cg_q <= mul_p[21:0];
      ST_WAITW: begin
        if (drsp.done) begin
          if (wsel_q) tr_q <= travel;
          else        tl_q <= travel;
        end
      end
      ST_HDIV: dneg_q <= gyro_q ? gdiff[16] : tdiff[32];
      ST_WAITH: if (drsp.done) dmag_q <= drsp.quot;
      ST_GI: dmag_q <= mul_p;
      ST_GF: dmag_q <= dmag_q + 64'(mul_p[63:38]);
      // dmag - estimate * period, exact in 29 bits
      ST_MR: mrem_q <= dmag_q[28:0] - mul_p[28:0];
      ST_MC: mrem_q <= mr2;
      ST_WAITC: begin
        if (cdone) begin
          cos_q <= ccos;
          sin_q <= csin;
        end
      end
      ST_DONE: begin
        if (!ov_q || out_o.ready) begin
          ox_q <= x_q;
          oy_q <= y_q;
          oh_q <= hd_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid   = ov_q;
  assign out_o.pos_x   = ox_q;
  assign out_o.pos_y   = oy_q;
  assign out_o.heading = oh_q;

endmodule
